[rtl/ihex_pkg.sv]
// ----------------------------------------------------------------------------
// ihex_pkg
// shared types, codes and helpers for the hex record reader
// ----------------------------------------------------------------------------
`default_nettype none
package ihex_pkg;

    localparam int RECORD_BYTES_DEF = 32;
    localparam int BLOCK_BYTES_DEF  = 16384;

    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_BLOCK = 2'd1,
        KIND_EOF   = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_START     = 3'd1,
        ERR_LONG      = 3'd2,
        ERR_CHECKSUM  = 3'd3,
        ERR_TYPE      = 3'd4,
        ERR_DIGIT     = 3'd5
    } t_err;

    typedef enum logic [2:0] {
        PH_WAIT      = 3'd0,
        PH_DIGITS    = 3'd1,
        PH_AFTER_SUM = 3'd2,
        PH_AFTER_CR  = 3'd3,
        PH_AFTER_LF  = 3'd4,
        PH_HALT      = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        BS_IDLE  = 2'd0,
        BS_PAGE1 = 2'd1,
        BS_DATA  = 2'd2
    } t_bstate;

    // command codes passed from the parser to the executor
    typedef enum logic [2:0] {
        CMD_ACT   = 3'd0,
        CMD_EOF   = 3'd1,
        CMD_FAIL  = 3'd2
    } t_cmd;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [14:0] byte_offset;
        logic [15:0] block_addr;
        logic [15:0] page_number;
        logic        section_flag;
        logic [2:0]  error_code;
        logic        last;
    } t_out;

    // one queued command; an act also carries a trailing error for the
    // character that follows an acted record
    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  rec_type;
        logic [7:0]  rec_len;
        logic [15:0] rec_addr;
        t_err        err;
        logic        then_fail;
    } t_job;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            r = {1'b0, c[3:0] + 4'd9};
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/ihex_ram.sv]
// ----------------------------------------------------------------------------
// ihex_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module ihex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/ihex_front.sv]
// ----------------------------------------------------------------------------
// ihex_front
// character parser: assembles records, checks them and queues commands
// ----------------------------------------------------------------------------
`default_nettype none
module ihex_front #(
    parameter int RECORD_BYTES = ihex_pkg::RECORD_BYTES_DEF,
    localparam int AW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ihex_pkg::t_in i_item,
    output logic               o_full,
    // buffer write port
    output logic               o_we,
    output logic [AW-1:0]      o_waddr,
    output logic [7:0]         o_wdata,
    // command queue
    output logic               o_job_valid,
    output ihex_pkg::t_job     o_job,
    input  wire logic          i_job_ready,
    input  wire logic          i_back_busy
);
    // byte index covers header, data and checksum; digit count is twice that
    localparam int IW = $clog2(RECORD_BYTES + 6);
    localparam int CW = IW + 1;

    ihex_pkg::t_phase r_phase, n_phase;
    logic [3:0]    r_nib, n_nib;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [7:0]    r_len, n_len;
    logic [15:0]   r_addr, n_addr;
    logic [7:0]    r_type, n_type;
    logic [7:0]    r_sum, n_sum;

    logic          take;
    logic [4:0]    hv;
    logic [7:0]    b;
    logic [IW-1:0] idx;
    logic [7:0]    sum_next;
    ihex_pkg::t_job job;
    logic          job_go;
    logic          eoi, is_colon;

    // queue depth one: the executor must be idle before an act is sent so
    // that buffer writes of the next record never overtake it
    assign o_full = o_job_valid || i_back_busy;
    assign take   = i_push && !o_full;
    assign eoi    = i_item.end_of_input;
    assign is_colon = (i_item.char_code == ihex_pkg::CH_COLON);
    assign hv     = ihex_pkg::hex_val(i_item.char_code);
    assign b      = {r_nib, hv[3:0]};
    assign idx    = r_cnt[CW-1:1];
    assign sum_next = r_sum + b;

    always_comb begin
        n_phase = r_phase; n_nib = r_nib; n_cnt = r_cnt; n_len = r_len;
        n_addr = r_addr; n_type = r_type; n_sum = r_sum;
        job = '{cmd: ihex_pkg::CMD_FAIL, rec_type: r_type, rec_len: r_len,
                rec_addr: r_addr, err: ihex_pkg::ERR_NONE, then_fail: 1'b0};
        job_go = 1'b0;
        o_we = 1'b0;
        o_waddr = AW'(idx - IW'(4));
        o_wdata = b;
        if (take) begin
            case (r_phase)
                ihex_pkg::PH_WAIT: begin
                    if (!eoi && is_colon) begin
                        n_phase = ihex_pkg::PH_DIGITS;
                        n_cnt = '0; n_nib = '0; n_sum = '0;
                    end else begin
                        job_go = 1'b1; job.err = ihex_pkg::ERR_START;
                        n_phase = ihex_pkg::PH_HALT;
                    end
                end
                ihex_pkg::PH_DIGITS: begin
                    if (eoi || hv[4]) begin
                        job_go = 1'b1; job.err = ihex_pkg::ERR_DIGIT;
                        n_phase = ihex_pkg::PH_HALT;
                    end else if (!r_cnt[0]) begin
                        n_nib = hv[3:0];
                        n_cnt = r_cnt + CW'(1);
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                        n_sum = sum_next;
                        if (idx == IW'(0)) n_len = b;
                        else if (idx == IW'(1)) n_addr = {b, 8'h00};
                        else if (idx == IW'(2)) n_addr = {r_addr[15:8], b};
                        else if (idx == IW'(3)) begin
                            n_type = b;
                            if (r_len > 8'(RECORD_BYTES)) begin
                                job_go = 1'b1; job.err = ihex_pkg::ERR_LONG;
                                n_phase = ihex_pkg::PH_HALT;
                            end
                        end else if (16'(idx) - 16'd4 < 16'(r_len)) begin
                            o_we = 1'b1;
                        end else if (sum_next != 8'h00) begin
                            job_go = 1'b1; job.err = ihex_pkg::ERR_CHECKSUM;
                            n_phase = ihex_pkg::PH_HALT;
                        end else begin
                            n_phase = ihex_pkg::PH_AFTER_SUM;
                        end
                    end
                end
                ihex_pkg::PH_AFTER_SUM: begin
                    if (!eoi && i_item.char_code == ihex_pkg::CH_CR)
                        n_phase = ihex_pkg::PH_AFTER_CR;
                    else if (!eoi && i_item.char_code == ihex_pkg::CH_LF)
                        n_phase = ihex_pkg::PH_AFTER_LF;
                    else begin
                        job_go = 1'b1; job.cmd = ihex_pkg::CMD_EOF;
                        n_phase = ihex_pkg::PH_HALT;
                    end
                end
                ihex_pkg::PH_AFTER_CR: begin
                    if (!eoi && i_item.char_code == ihex_pkg::CH_LF)
                        n_phase = ihex_pkg::PH_AFTER_LF;
                    else begin
                        job_go = 1'b1; job.cmd = ihex_pkg::CMD_EOF;
                        n_phase = ihex_pkg::PH_HALT;
                    end
                end
                ihex_pkg::PH_AFTER_LF: begin
                    job_go = 1'b1;
                    if (eoi) begin
                        job.cmd = ihex_pkg::CMD_EOF;
                        n_phase = ihex_pkg::PH_HALT;
                    end else begin
                        job.cmd = ihex_pkg::CMD_ACT;
                        if (is_colon && r_type <= 8'd2) begin
                            n_phase = ihex_pkg::PH_DIGITS;
                            n_cnt = '0; n_nib = '0; n_sum = '0;
                        end else begin
                            job.then_fail = !is_colon;
                            job.err = ihex_pkg::ERR_START;
                            n_phase = ihex_pkg::PH_HALT;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ihex_pkg::PH_WAIT;
            r_nib <= '0; r_cnt <= '0; r_len <= '0; r_addr <= '0;
            r_type <= '0; r_sum <= '0;
            o_job_valid <= 1'b0;
        end else begin
            r_phase <= n_phase; r_nib <= n_nib; r_cnt <= n_cnt; r_len <= n_len;
            r_addr <= n_addr; r_type <= n_type; r_sum <= n_sum;
            if (job_go) o_job_valid <= 1'b1;
            else if (i_job_ready) o_job_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_go) o_job <= job;
    end

    // a halted parser never raises another command
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == ihex_pkg::PH_HALT |=> !job_go)
        else $error("command issued after halt");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> r_phase == ihex_pkg::PH_DIGITS)
        else $error("buffer write outside digits");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_go |-> !o_job_valid)
        else $error("command queue overrun");
endmodule
`default_nettype wire

[rtl/ihex_back.sv]
// ----------------------------------------------------------------------------
// ihex_back
// executor: carries out queued commands and feeds the result queue
// ----------------------------------------------------------------------------
`default_nettype none
module ihex_back #(
    parameter int RECORD_BYTES = ihex_pkg::RECORD_BYTES_DEF,
    parameter int BLOCK_BYTES  = ihex_pkg::BLOCK_BYTES_DEF,
    localparam int AW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_job_valid,
    input  wire ihex_pkg::t_job i_job,
    output logic                o_job_ready,
    output logic                o_busy,
    output logic [AW-1:0]       o_raddr,
    input  wire logic [7:0]     i_rdata,
    output logic                o_empty,
    output ihex_pkg::t_out      o_result,
    input  wire logic           i_pop
);
    ihex_pkg::t_bstate r_st, n_st;
    ihex_pkg::t_job    r_job, n_job;
    logic [14:0] r_off, n_off;
    logic [15:0] r_caddr, n_caddr;
    logic [15:0] r_page, n_page;
    logic        r_flag, n_flag, r_ppend, n_ppend;
    logic [7:0]  r_i, n_i;
    logic [7:0]  r_b0, n_b0;
    ihex_pkg::t_out res;
    logic        emit;
    logic        can_emit;

    assign can_emit = o_empty || i_pop;
    assign o_busy   = (r_st != ihex_pkg::BS_IDLE);
    assign o_job_ready = !o_busy && can_emit;
    // registered read: i_rdata holds byte r_i-1, so address byte n_i-1
    assign o_raddr  = AW'(n_i - 8'd1);

    always_comb begin
        n_st = r_st; n_job = r_job; n_off = r_off; n_caddr = r_caddr;
        n_page = r_page; n_flag = r_flag; n_ppend = r_ppend; n_i = r_i;
        n_b0 = r_b0;
        emit = 1'b0;
        res = '{kind: ihex_pkg::KIND_ERROR, data_byte: 8'h00, byte_offset: r_off,
                block_addr: r_caddr, page_number: r_page, section_flag: r_flag,
                error_code: ihex_pkg::ERR_NONE, last: 1'b1};
        case (r_st)
            ihex_pkg::BS_IDLE: begin
                if (i_job_valid && can_emit) begin
                    n_job = i_job;
                    case (i_job.cmd)
                        ihex_pkg::CMD_FAIL: begin
                            emit = 1'b1; res.error_code = i_job.err;
                        end
                        ihex_pkg::CMD_EOF: begin
                            if (r_ppend) begin
                                n_caddr = i_job.rec_addr; res.block_addr = i_job.rec_addr;
                            end
                            n_ppend = 1'b0;
                            emit = 1'b1; res.kind = ihex_pkg::KIND_EOF;
                            res.block_addr = r_ppend ? i_job.rec_addr : r_caddr;
                        end
                        default: begin
                            n_st = ihex_pkg::BS_DATA; n_i = '0;
                            if (r_ppend) n_caddr = i_job.rec_addr;
                            n_ppend = 1'b0;
                            if (i_job.rec_type == 8'd2) n_st = ihex_pkg::BS_PAGE1;
                            // for data and page records, reads begin at index 0
                            n_i = (i_job.rec_type == 8'd0 || i_job.rec_type == 8'd2)
                                  ? 8'd1 : 8'd0;
                        end
                    endcase
                end
            end
            ihex_pkg::BS_PAGE1: begin
                // i_rdata is byte 0 here; read byte 1 next
                n_b0 = i_rdata; n_st = ihex_pkg::BS_DATA; n_i = 8'd2;
            end
            default: begin
                case (r_job.rec_type)
                    8'd0: begin
                        if (r_i - 8'd1 >= r_job.rec_len) begin
                            if (r_job.then_fail) begin
                                if (can_emit) begin
                                    emit = 1'b1; res.error_code = r_job.err;
                                    n_st = ihex_pkg::BS_IDLE;
                                end
                            end else n_st = ihex_pkg::BS_IDLE;
                        end else if (can_emit) begin
                            emit = 1'b1; res.kind = ihex_pkg::KIND_DATA;
                            res.data_byte = i_rdata;
                            res.last = !r_job.then_fail && (r_i >= r_job.rec_len);
                            n_off = r_off + 15'd1;
                            n_i = r_i + 8'd1;
                            if ({1'b0, r_off} + 16'd1 >= 16'(BLOCK_BYTES)) begin
                                // block cap: emit completion, drop the rest
                                n_job.rec_type = 8'd4;
                                n_st = ihex_pkg::BS_PAGE1;
                                n_job.rec_len = 8'hff;
                                res.last = 1'b0;
                            end
                        end
                    end
                    8'd1: begin
                        if (r_off != '0 && !r_i[0]) begin
                            if (can_emit) begin
                                emit = 1'b1; res.kind = ihex_pkg::KIND_BLOCK;
                                res.last = !r_job.then_fail;
                                n_off = '0; n_ppend = 1'b0; n_i = 8'd1;
                            end
                        end else if (r_job.then_fail) begin
                            if (can_emit) begin
                                n_caddr = '0; n_page = '0; n_flag = !r_flag;
                                emit = 1'b1; res.error_code = r_job.err;
                                res.block_addr = '0; res.page_number = '0;
                                res.section_flag = !r_flag;
                                n_st = ihex_pkg::BS_IDLE;
                            end
                        end else begin
                            n_caddr = '0; n_page = '0; n_flag = !r_flag;
                            n_st = ihex_pkg::BS_IDLE;
                        end
                    end
                    8'd2: begin
                        if (r_i == 8'd2) begin
                            n_page = {r_b0, i_rdata}; n_ppend = 1'b1; n_i = 8'd3;
                            if (!r_job.then_fail) n_st = ihex_pkg::BS_IDLE;
                        end else if (can_emit) begin
                            emit = 1'b1; res.error_code = r_job.err;
                            n_st = ihex_pkg::BS_IDLE;
                        end
                    end
                    8'd3: begin
                        if (can_emit) begin
                            emit = 1'b1; res.kind = ihex_pkg::KIND_EOF;
                            n_st = ihex_pkg::BS_IDLE;
                        end
                    end
                    default: begin
                        if (can_emit) begin
                            emit = 1'b1;
                            res.error_code = r_job.err;
                            n_st = ihex_pkg::BS_IDLE;
                            if (r_job.rec_len == 8'hff) begin
                                // tail of a capped block
                                res.kind = ihex_pkg::KIND_BLOCK;
                                res.error_code = ihex_pkg::ERR_NONE;
                                n_off = '0; n_ppend = 1'b0;
                                n_job.rec_len = '0; n_job.rec_type = 8'd3;
                                res.last = !r_job.then_fail;
                                n_st = r_job.then_fail ? ihex_pkg::BS_DATA
                                                       : ihex_pkg::BS_IDLE;
                                n_job.rec_type = 8'd0;
                                n_i = 8'd1;
                            end else begin
                                res.error_code = ihex_pkg::ERR_TYPE;
                            end
                        end
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ihex_pkg::BS_IDLE;
            r_off <= '0; r_caddr <= '0; r_page <= '0; r_flag <= 1'b1;
            r_ppend <= 1'b0; r_i <= '0;
            o_empty <= 1'b1;
        end else begin
            r_st <= n_st; r_off <= n_off; r_caddr <= n_caddr; r_page <= n_page;
            r_flag <= n_flag; r_ppend <= n_ppend; r_i <= n_i;
            if (emit) o_empty <= 1'b0;
            else if (i_pop) o_empty <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job; r_b0 <= n_b0;
        if (emit) o_result <= res;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> can_emit)
        else $error("result overwritten");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_job_valid && o_job_ready) |-> r_st == ihex_pkg::BS_IDLE)
        else $error("command taken while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && res.kind != ihex_pkg::KIND_ERROR |-> res.error_code == ihex_pkg::ERR_NONE)
        else $error("error code on non-error result");
endmodule
`default_nettype wire

[rtl/intel_hex_block_reader_unit.sv]
// ----------------------------------------------------------------------------
// intel_hex_block_reader_unit
// hex record reader: characters in, data bytes and block events out
// ----------------------------------------------------------------------------
// usage
//   input queue: present one character (or end of input) with push; it is
//   taken when full is low. results appear while empty is low and are
//   removed with pop; each result's last bit closes one input transaction.
//   the front parser takes one character a cycle while it only assembles a
//   record; when a record is acted on it hands a command to the executor and
//   stalls (full high) until the executor finishes. the executor reads a
//   data record's bytes through the registered read of the record buffer;
//   commands pass through a command register and results through a result
//   register.
//   a stalled receiver (pop low) holds the executor and then the parser.
//   reset (synchronous, active low) returns to waiting for a ':' with the
//   flag set; the record buffer is not cleared. errors and end of file halt
//   the reader until reset.
// ----------------------------------------------------------------------------
`default_nettype none
module intel_hex_block_reader_unit #(
    parameter int RECORD_BYTES = ihex_pkg::RECORD_BYTES_DEF,
    parameter int BLOCK_BYTES  = ihex_pkg::BLOCK_BYTES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           push,
    input  wire ihex_pkg::t_in  i_item,
    output logic                full,
    output logic                empty,
    output ihex_pkg::t_out      o_result,
    input  wire logic           pop
);
    localparam int AW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

    // buffer ports
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;
    // command channel between parser and executor
    logic           job_valid, job_ready, back_busy;
    ihex_pkg::t_job job;

    ihex_front #(.RECORD_BYTES(RECORD_BYTES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_item(i_item),
        .o_full(full), .o_we(we), .o_waddr(waddr), .o_wdata(wdata),
        .o_job_valid(job_valid), .o_job(job), .i_job_ready(job_ready),
        .i_back_busy(back_busy)
    );

    ihex_ram #(.WIDTH(8), .DEPTH(RECORD_BYTES)) u_buf (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    ihex_back #(.RECORD_BYTES(RECORD_BYTES), .BLOCK_BYTES(BLOCK_BYTES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(job_valid), .i_job(job),
        .o_job_ready(job_ready), .o_busy(back_busy), .o_raddr(raddr),
        .i_rdata(rdata), .o_empty(empty), .o_result(o_result), .i_pop(pop)
    );

    // an input transaction is never taken while the executor works
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_busy |-> full)
        else $error("input taken during execution");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_valid |-> full)
        else $error("input taken with command pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> !back_busy)
        else $error("buffer written during execution");
endmodule
`default_nettype wire

[bench/intel_hex_block_reader_unit_test.sv]
// ----------------------------------------------------------------------------
// intel_hex_block_reader_unit_test
// self-checking bench for the hex record reader: a stream of hex records,
// one character per transaction, goes in through bursts with random gaps.
// a predictor in the bench works out every expected result, and the result
// queue, popped on a random stall pattern, is checked field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module intel_hex_block_reader_unit_test;

    localparam int REC_MAX      = 32;
    localparam int BLK_MAX      = 16384;
    localparam int STALL_LIMIT  = 5000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    ihex_pkg::t_in  i_item = '0;
    logic full;
    logic empty;
    ihex_pkg::t_out o_result;

    intel_hex_block_reader_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .i_item  (i_item),
        .full    (full),
        .empty   (empty),
        .o_result(o_result),
        .pop     (pop)
    );

    always #4 i_clk = ~i_clk;

    // characters still to send, and results the predictor says must come out
    ihex_pkg::t_in  char_q[$];
    ihex_pkg::t_out result_q[$];
    int   mismatches = 0;

    // ------------------------------------------------------------------------
    // predictor state: parser, record buffer and block bookkeeping
    // ------------------------------------------------------------------------
    ihex_pkg::t_phase ph = ihex_pkg::PH_WAIT;
    logic [3:0] hi_nib = '0;
    int         n_digits = 0;
    int         rec_len = 0;
    logic [15:0] rec_addr = '0;
    logic [7:0] rec_type = '0;
    logic [7:0] rec_sum = '0;
    logic [7:0] rec_buf [REC_MAX];
    int         blk_fill = 0;
    logic [15:0] cur_addr = '0;
    logic [15:0] cur_page = '0;
    logic       sect_flag = 1'b1;
    logic       page_armed = 1'b0;
    logic       stopped = 1'b0;

    task automatic post(input ihex_pkg::t_kind k, input logic [7:0] d, input int off,
                        input ihex_pkg::t_err e);
        ihex_pkg::t_out r;
        r.kind         = k;
        r.data_byte    = d;
        r.byte_offset  = off[14:0];
        r.block_addr   = cur_addr;
        r.page_number  = cur_page;
        r.section_flag = sect_flag;
        r.error_code   = e;
        r.last         = 1'b0;
        result_q.push_back(r);
    endtask

    task automatic halt_on(input ihex_pkg::t_err e);
        post(ihex_pkg::KIND_ERROR, 8'h00, blk_fill, e);
        stopped = 1'b1;
    endtask

    task automatic close_block();
        post(ihex_pkg::KIND_BLOCK, 8'h00, blk_fill, ihex_pkg::ERR_NONE);
        blk_fill = 0;
        page_armed = 1'b0;
    endtask

    task automatic begin_record();
        ph = ihex_pkg::PH_DIGITS;
        n_digits = 0;
        hi_nib = '0;
        rec_sum = '0;
    endtask

    // carry out a buffered record of the given type
    task automatic run_record(input logic [7:0] t);
        if (page_armed) begin
            cur_addr = rec_addr;
            page_armed = 1'b0;
        end
        case (t)
            8'd0: begin
                for (int i = 0; i < rec_len; i++) begin
                    post(ihex_pkg::KIND_DATA, rec_buf[i], blk_fill, ihex_pkg::ERR_NONE);
                    blk_fill++;
                    if (blk_fill >= BLK_MAX) begin
                        close_block();
                        break;
                    end
                end
            end
            8'd1: begin
                if (blk_fill != 0) close_block();
                cur_addr = '0;
                cur_page = '0;
                sect_flag = ~sect_flag;
            end
            8'd2: begin
                cur_page = {rec_buf[0], rec_buf[1]};
                page_armed = 1'b1;
            end
            8'd3: begin
                post(ihex_pkg::KIND_EOF, 8'h00, blk_fill, ihex_pkg::ERR_NONE);
                stopped = 1'b1;
            end
            default: halt_on(ihex_pkg::ERR_TYPE);
        endcase
    endtask

    task automatic take_nibble(input logic [3:0] v);
        logic [7:0] b;
        int idx;
        if (n_digits % 2 == 0) begin
            hi_nib = v;
            n_digits++;
            return;
        end
        b = {hi_nib, v};
        idx = n_digits / 2;
        n_digits++;
        rec_sum = rec_sum + b;
        if (idx == 0) rec_len = int'(b);
        else if (idx == 1) rec_addr = {b, 8'h00};
        else if (idx == 2) rec_addr[7:0] = b;
        else if (idx == 3) begin
            rec_type = b;
            if (rec_len > REC_MAX) halt_on(ihex_pkg::ERR_LONG);
        end else if (idx - 4 < rec_len) rec_buf[idx - 4] = b;
        else if (rec_sum != 0) halt_on(ihex_pkg::ERR_CHECKSUM);
        else ph = ihex_pkg::PH_AFTER_SUM;
    endtask

    // one accepted character: queue up every result it causes
    task automatic predict_char(input ihex_pkg::t_in it);
        int n0;
        logic [7:0] c;
        logic [4:0] v;
        n0 = result_q.size();
        c = it.char_code;
        if (stopped) return;
        v = 5'h10;
        if (c >= "0" && c <= "9") v = 5'(c - "0");
        else if (c >= "A" && c <= "F") v = 5'(c - "A" + 8'd10);
        else if (c >= "a" && c <= "f") v = 5'(c - "a" + 8'd10);
        case (ph)
            ihex_pkg::PH_WAIT: begin
                if (!it.end_of_input && c == ihex_pkg::CH_COLON) begin_record();
                else halt_on(ihex_pkg::ERR_START);
            end
            ihex_pkg::PH_DIGITS: begin
                if (it.end_of_input || v[4]) halt_on(ihex_pkg::ERR_DIGIT);
                else take_nibble(v[3:0]);
            end
            ihex_pkg::PH_AFTER_SUM: begin
                if (!it.end_of_input && c == ihex_pkg::CH_CR) ph = ihex_pkg::PH_AFTER_CR;
                else if (!it.end_of_input && c == ihex_pkg::CH_LF)
                    ph = ihex_pkg::PH_AFTER_LF;
                else run_record(8'd3);
            end
            ihex_pkg::PH_AFTER_CR: begin
                if (!it.end_of_input && c == ihex_pkg::CH_LF) ph = ihex_pkg::PH_AFTER_LF;
                else run_record(8'd3);
            end
            default: begin
                if (it.end_of_input) run_record(8'd3);
                else begin
                    run_record(rec_type);
                    if (!stopped) begin
                        if (c == ihex_pkg::CH_COLON) begin_record();
                        else halt_on(ihex_pkg::ERR_START);
                    end
                end
            end
        endcase
        if (result_q.size() > n0) result_q[result_q.size() - 1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // stimulus builders: characters of hex text into the send queue
    // ------------------------------------------------------------------------
    logic [7:0] payload [256];
    logic [7:0] gen_sum;

    task automatic put_char(input logic [7:0] c);
        ihex_pkg::t_in it;
        it.char_code = c;
        it.end_of_input = 1'b0;
        char_q.push_back(it);
    endtask

    task automatic put_end();
        ihex_pkg::t_in it;
        it.char_code = 8'($urandom_range(0, 255));
        it.end_of_input = 1'b1;
        char_q.push_back(it);
    endtask

    function automatic logic [7:0] digit_char(input logic [3:0] n);
        if (n < 10) return 8'("0" + n);
        return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 10);
    endfunction

    task automatic put_hex(input logic [7:0] b);
        put_char(digit_char(b[7:4]));
        put_char(digit_char(b[3:0]));
        gen_sum = gen_sum + b;
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ':' plus a whole record; sum_skew != 0 spoils the checksum
    task automatic put_record(input logic [7:0] t, input int len,
                              input logic [15:0] addr, input logic [7:0] sum_skew);
        gen_sum = '0;
        put_char(ihex_pkg::CH_COLON);
        put_hex(len[7:0]);
        put_hex(addr[15:8]);
        put_hex(addr[7:0]);
        put_hex(t);
        for (int i = 0; i < len; i++) put_hex(payload[i]);
        put_hex(8'h00 - gen_sum + sum_skew);
    endtask

    task automatic put_eol();
        if ($urandom_range(0, 1)) put_char(ihex_pkg::CH_CR);
        put_char(ihex_pkg::CH_LF);
    endtask

    task automatic fill_payload(input int len);
        for (int i = 0; i < len; i++) payload[i] = rand_byte();
    endtask

    // a well-formed record of random kind followed by a line end
    task automatic put_random_record();
        int len;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            len = ($urandom_range(0, 5) == 0) ? REC_MAX : $urandom_range(0, 16);
            fill_payload(len);
            put_record(8'd0, len, 16'($urandom_range(0, 65535)), 8'h00);
        end else if (pick < 9) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : 2;
            fill_payload(len);
            put_record(8'd2, len, 16'($urandom_range(0, 65535)), 8'h00);
        end else begin
            put_record(8'd1, 0, 16'($urandom_range(0, 65535)), 8'h00);
        end
        put_eol();
    endtask

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") ||
               (c >= "a" && c <= "f");
    endfunction

    // how the text ends; every ending halts the reader for good
    task automatic put_ending();
        logic [7:0] c;
        int len;
        fill_payload(4);
        case ($urandom_range(0, 9))
            0: begin                            // end of file record
                put_record(8'd3, 0, 16'h0000, 8'h00);
                put_eol();
                put_char(ihex_pkg::CH_COLON);
            end
            1: put_end();                       // text ends after a line end
            2: begin                            // stray character after a line end
                do c = 8'($urandom_range(0, 255)); while (c == ihex_pkg::CH_COLON);
                put_char(c);
            end
            3: begin                            // bad digit inside a record
                put_char(ihex_pkg::CH_COLON);
                for (int i = 0; i < $urandom_range(0, 12); i++)
                    put_char(digit_char(4'($urandom_range(0, 15))));
                do c = 8'($urandom_range(0, 255)); while (is_hex(c));
                put_char(c);
            end
            4: begin                            // length above the record limit
                len = $urandom_range(REC_MAX + 1, 255);
                put_char(ihex_pkg::CH_COLON);
                put_hex(len[7:0]);
                put_hex(rand_byte());
                put_hex(rand_byte());
                put_hex(8'h00);
            end
            5: put_record(8'd0, 4, 16'h1234, 8'($urandom_range(1, 255)));
            6: begin                            // unknown record type
                put_record(8'($urandom_range(4, 255)), 2, 16'h0000, 8'h00);
                put_eol();
                put_char(ihex_pkg::CH_COLON);
            end
            7: begin                            // junk where a line end belongs
                put_record(8'd0, 4, 16'h0100, 8'h00);
                do c = 8'($urandom_range(0, 255));
                while (c == ihex_pkg::CH_CR || c == ihex_pkg::CH_LF);
                if ($urandom_range(0, 3) == 0) put_end(); else put_char(c);
            end
            8: begin                            // CR without LF
                put_record(8'd0, 4, 16'h0100, 8'h00);
                put_char(ihex_pkg::CH_CR);
                do c = 8'($urandom_range(0, 255)); while (c == ihex_pkg::CH_LF);
                put_char(c);
            end
            default: begin                      // text ends inside a record
                put_char(ihex_pkg::CH_COLON);
                put_hex(8'h02);
                put_end();
            end
        endcase
        // ignored traffic once halted, so every input bit toggles
        for (int i = 0; i < 24; i++) begin
            if ($urandom_range(0, 3) == 0) put_end();
            else put_char(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic build_text();
        int base;
        // directed: full record first, so later short page records only
        // read buffer entries that were written
        for (int i = 0; i < REC_MAX; i++) payload[i] = i[0] ? 8'hff : 8'h00;
        payload[5] = 8'h5a;
        put_record(8'd0, REC_MAX, 16'h0000, 8'h00);
        put_char(ihex_pkg::CH_CR);
        put_char(ihex_pkg::CH_LF);
        put_record(8'd0, 0, 16'hffff, 8'h00);
        put_char(ihex_pkg::CH_LF);
        payload[0] = 8'hff;
        payload[1] = 8'hff;
        put_record(8'd2, 2, 16'h0000, 8'h00);
        put_char(ihex_pkg::CH_CR);
        put_char(ihex_pkg::CH_LF);
        payload[0] = 8'hc3;
        put_record(8'd0, 1, 16'hffff, 8'h00);    // takes the block address
        put_char(ihex_pkg::CH_LF);
        put_record(8'd1, 0, 16'h0000, 8'h00);    // closes a non-empty block
        put_char(ihex_pkg::CH_LF);
        put_record(8'd2, 0, 16'h0010, 8'h00);    // short page records
        put_char(ihex_pkg::CH_LF);
        payload[0] = 8'h01;
        put_record(8'd2, 1, 16'h0020, 8'h00);
        put_char(ihex_pkg::CH_LF);
        put_record(8'd1, 0, 16'h0000, 8'h00);    // empty block end
        put_char(ihex_pkg::CH_LF);

        // random well-formed records
        base = char_q.size();
        while (char_q.size() - base < 280) put_random_record();
        put_ending();
    endtask

    // ------------------------------------------------------------------------
    // driver: bursts of characters with random gaps, changed on falling edge
    // ------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left = 0;
    int stall_step = 0;
    logic [15:0] stall_mask = '0;

    always @(negedge i_clk) begin
        logic nxt_push;
        nxt_push = 1'b0;
        if (i_rst_n) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (char_q.size() > 0) begin
                nxt_push = 1'b1;
                i_item <= char_q[0];
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 60);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            // receiver: a random stall pattern, redrawn at intervals, sometimes none
            if (stall_step % 256 == 0)
                stall_mask = ($urandom_range(0, 3) == 0) ? '0
                                                         : 16'($urandom_range(0, 65535));
            pop <= ~stall_mask[stall_step % 16];
            stall_step++;
        end
        push <= nxt_push;
    end

    // ------------------------------------------------------------------------
    // monitor: predict on accepted characters, check accepted results
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        ihex_pkg::t_in  it;
        ihex_pkg::t_out want;
        if (i_rst_n) begin
            quiet_cycles++;
            if (push && !full) begin
                it = char_q.pop_front();
                predict_char(it);
                quiet_cycles = 0;
            end
            if (pop && !empty) begin
                quiet_cycles = 0;
                if (result_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: %p", o_result);
                end else begin
                    want = result_q.pop_front();
                    if (o_result.kind !== want.kind ||
                        o_result.data_byte !== want.data_byte ||
                        o_result.byte_offset !== want.byte_offset ||
                        o_result.block_addr !== want.block_addr ||
                        o_result.page_number !== want.page_number ||
                        o_result.section_flag !== want.section_flag ||
                        o_result.error_code !== want.error_code ||
                        o_result.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p, got %p",
                                     want, o_result);
                    end
                end
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("intel_hex_block_reader_unit_test NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // sequence: build the text, reset once, drain, report
    // ------------------------------------------------------------------------
    initial begin
        build_text();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (char_q.size() != 0 || result_q.size() != 0) @(posedge i_clk);
        // let anything unexpected surface before the verdict
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && result_q.size() == 0)
            $display("intel_hex_block_reader_unit_test OK");
        else
            $display("intel_hex_block_reader_unit_test NOT OK");
        $finish;
    end

endmodule
`default_nettype wire
